// File: rtl/pfc_pkg.sv
// Shared types, codes and helper functions for the Playfair digraph cipher.
// Used by the interfaces, controller, datapath and top level.
package pfc_pkg;

  localparam int unsigned LETTER_W = 5;
  localparam int unsigned SIDE     = 5;
  localparam int unsigned CELLS    = SIDE * SIDE;
  localparam int unsigned LETTERS  = 26;
  localparam int unsigned CELL_W   = $clog2(CELLS);
  localparam int unsigned FILL_W   = $clog2(CELLS + 1);
  localparam int unsigned POS_W    = $clog2(SIDE);

  localparam logic [LETTER_W-1:0] OMIT_RESET = LETTER_W'(16);
  localparam logic [LETTER_W-1:0] PAD_RESET  = LETTER_W'(25);

  localparam logic [LETTER_W-1:0] LAST_LETTER = LETTER_W'(LETTERS - 1);
  localparam logic [FILL_W-1:0]   FULL_COUNT  = FILL_W'(CELLS);
  localparam logic [POS_W-1:0]    LAST_POS    = POS_W'(SIDE - 1);

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_KEY     = 2'd1,
    OP_FINISH  = 2'd2,
    OP_ENCRYPT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_NOT_IN_SQUARE = 2'd1,
    ST_NOT_READY     = 2'd2
  } status_t;

  // Register map: index into the configuration list.
  typedef enum logic {
    REG_OMITTED = 1'b0,
    REG_PAD     = 1'b1
  } reg_idx_t;

  // Controller to datapath.
  typedef struct packed {
    logic latch;      // capture an accepted item
    logic execute;    // perform the item's action and load the result register
    logic walk_step;  // place one alphabet letter during finish
    logic set_ready;  // mark the square complete
  } pfc_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    op_t  op;
    logic square_ready;
    logic walk_last;
    logic out_free;
  } pfc_stat_t;

  // Row of a cell index 0..24.
  function automatic logic [POS_W-1:0] row_of(input logic [CELL_W-1:0] p);
    logic [POS_W-1:0] r;
    if (p >= CELL_W'(4 * SIDE))      r = POS_W'(4);
    else if (p >= CELL_W'(3 * SIDE)) r = POS_W'(3);
    else if (p >= CELL_W'(2 * SIDE)) r = POS_W'(2);
    else if (p >= CELL_W'(SIDE))     r = POS_W'(1);
    else                             r = POS_W'(0);
    return r;
  endfunction

  function automatic logic [POS_W-1:0] col_of(input logic [CELL_W-1:0] p);
    logic [CELL_W-1:0] base;
    base = CELL_W'(row_of(p) * SIDE);
    return POS_W'(p - base);
  endfunction

  function automatic logic [POS_W-1:0] step_pos(input logic [POS_W-1:0] v);
    return (v == LAST_POS) ? '0 : POS_W'(v + 1'b1);
  endfunction

  function automatic logic [CELL_W-1:0] cell_addr(input logic [POS_W-1:0] r,
                                                  input logic [POS_W-1:0] c);
    return CELL_W'({r, 2'b00}) + CELL_W'(r) + CELL_W'(c);
  endfunction

endpackage

// File: rtl/pfc_in_if.sv
// Input channel of the Playfair cipher: valid/ready handshake and one item.
// Depends on pfc_pkg for field widths.
interface pfc_in_if import pfc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          operation;
  logic [LETTER_W-1:0] letter_first;
  logic [LETTER_W-1:0] letter_second;
  logic                unpaired;

  modport source (output valid, operation, letter_first, letter_second, unpaired,
                  input ready);
  modport sink   (input valid, operation, letter_first, letter_second, unpaired,
                  output ready);
endinterface

// File: rtl/pfc_out_if.sv
// Result channel of the Playfair cipher: valid/ready handshake and one result.
// Depends on pfc_pkg for field widths.
interface pfc_out_if import pfc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LETTER_W-1:0] cipher_first;
  logic [LETTER_W-1:0] cipher_second;
  logic [1:0]          status;

  modport source (output valid, cipher_first, cipher_second, status, input ready);
  modport sink   (input valid, cipher_first, cipher_second, status, output ready);
endinterface

// File: rtl/pfc_ctrl.sv
// Sequencer of the Playfair cipher: accept, execute, alphabet walk.
// Depends on pfc_pkg for command and status structs.
module pfc_ctrl import pfc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  pfc_stat_t stat,
  output pfc_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.op == OP_FINISH && !stat.square_ready) begin
          state_next = S_WALK;
        end else if (stat.out_free) begin
          cmd.execute = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_last) begin
          cmd.set_ready = 1'b1;
          state_next    = S_EXEC;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_walk_only_unfinished: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (stat.op == OP_FINISH && !stat.square_ready))
    else $error("walk running on a finished square or a non-finish item");

  a_exec_needs_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |-> stat.out_free)
    else $error("result loaded while the result register is occupied");

  a_walk_returns: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && stat.walk_last) |=> (state == S_EXEC && stat.square_ready))
    else $error("walk ended without marking the square ready");

endmodule

// File: rtl/pfc_datapath.sv
// Datapath of the Playfair cipher: key square and letter position memories,
// used bits, fill count, alphabet walk counter and result register.
// Depends on pfc_pkg.
module pfc_datapath import pfc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  pfc_cmd_t            cmd,
  output pfc_stat_t           stat,
  input  logic [LETTER_W-1:0] omitted_letter,
  input  logic [LETTER_W-1:0] pad_letter,
  input  logic [1:0]          in_operation,
  input  logic [LETTER_W-1:0] in_letter_first,
  input  logic [LETTER_W-1:0] in_letter_second,
  input  logic                in_unpaired,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [LETTER_W-1:0] out_cipher_first,
  output logic [LETTER_W-1:0] out_cipher_second,
  output logic [1:0]          out_status
);

  // Memories: square cell -> letter, letter -> square cell.
  logic [LETTER_W-1:0] sq_mem [CELLS];
  logic [CELL_W-1:0]   lc_mem [LETTERS];

  logic [LETTERS-1:0]  letter_used;
  logic [FILL_W-1:0]   fill_count;
  logic                square_ready;
  logic [LETTER_W-1:0] walk_letter;

  op_t                 op;
  logic [LETTER_W-1:0] l1;
  logic [LETTER_W-1:0] l2;
  logic [CELL_W-1:0]   p1;
  logic [CELL_W-1:0]   p2;

  logic [LETTER_W-1:0] l2_in;
  logic                place_en;
  logic [LETTER_W-1:0] place_letter;
  logic                l1_valid;
  logic                l2_valid;
  logic                found;
  status_t             enc_status;
  status_t             res_status;
  logic [POS_W-1:0]    r1, k1, r2, k2;
  logic [CELL_W-1:0]   a1, a2;

  assign l2_in = in_unpaired ? pad_letter : in_letter_second;

  // Placement: key letter on execute, alphabet letter on each walk step.
  always_comb begin
    place_letter = cmd.walk_step ? walk_letter : l1;
    place_en     = 1'b0;
    if (place_letter <= LAST_LETTER && fill_count < FULL_COUNT
        && !letter_used[place_letter] && place_letter != omitted_letter) begin
      if (cmd.walk_step) begin
        place_en = 1'b1;
      end else if (cmd.execute && op == OP_KEY && !square_ready) begin
        place_en = 1'b1;
      end
    end
  end

  // Encrypt lookup.
  always_comb begin
    l1_valid = (l1 <= LAST_LETTER);
    l2_valid = (l2 <= LAST_LETTER);
    found    = l1_valid && l2_valid && letter_used[l1] && letter_used[l2];
    if (!square_ready)  enc_status = ST_NOT_READY;
    else if (!found)    enc_status = ST_NOT_IN_SQUARE;
    else                enc_status = ST_OK;

    r1 = row_of(p1);
    k1 = col_of(p1);
    r2 = row_of(p2);
    k2 = col_of(p2);
    priority if (k1 == k2) begin
      a1 = cell_addr(step_pos(r1), k1);
      a2 = cell_addr(step_pos(r2), k2);
    end else if (r1 == r2) begin
      a1 = cell_addr(r1, step_pos(k1));
      a2 = cell_addr(r2, step_pos(k2));
    end else begin
      a1 = cell_addr(r1, k2);
      a2 = cell_addr(r2, k1);
    end

    unique case (op)
      OP_ENCRYPT: res_status = enc_status;
      OP_KEY:     res_status = l1_valid ? ST_OK : ST_NOT_IN_SQUARE;
      OP_START,
      OP_FINISH:  res_status = ST_OK;
      default:    res_status = ST_OK;
    endcase
  end

  // Item capture and letter position read.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op <= op_t'(in_operation);
      l1 <= in_letter_first;
      l2 <= l2_in;
      p1 <= lc_mem[in_letter_first];
      p2 <= lc_mem[l2_in];
    end
  end

  // Memory writes.
  always_ff @(posedge clk) begin
    if (place_en) begin
      sq_mem[fill_count[CELL_W-1:0]] <= place_letter;
      lc_mem[place_letter]            <= fill_count[CELL_W-1:0];
    end
  end

  // Square build state.
  always_ff @(posedge clk) begin
    if (rst) begin
      letter_used  <= '0;
      fill_count   <= '0;
      square_ready <= 1'b0;
      walk_letter  <= '0;
    end else begin
      if (cmd.latch) begin
        walk_letter <= '0;
      end else if (cmd.walk_step) begin
        walk_letter <= walk_letter + 1'b1;
      end
      if (cmd.execute && op == OP_START) begin
        letter_used  <= '0;
        fill_count   <= '0;
        square_ready <= 1'b0;
      end else begin
        if (place_en) begin
          letter_used[place_letter] <= 1'b1;
          fill_count                <= fill_count + 1'b1;
        end
        if (cmd.set_ready) begin
          square_ready <= 1'b1;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.execute) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      out_status <= res_status;
      if (op == OP_ENCRYPT && enc_status == ST_OK) begin
        out_cipher_first  <= sq_mem[a1];
        out_cipher_second <= sq_mem[a2];
      end else begin
        out_cipher_first  <= '0;
        out_cipher_second <= '0;
      end
    end
  end

  assign stat.op           = op;
  assign stat.square_ready = square_ready;
  assign stat.walk_last    = (walk_letter == LAST_LETTER);
  assign stat.out_free     = !out_valid || out_ready;

  a_fill_matches_used: assert property (@(posedge clk) disable iff (rst)
    $countones(letter_used) == 32'(fill_count))
    else $error("fill count disagrees with the used letters");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FULL_COUNT)
    else $error("fill count beyond the square");

  a_error_zero_cipher: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != ST_OK) |->
      (out_cipher_first == '0 && out_cipher_second == '0))
    else $error("cipher letters not cleared on an error result");

endmodule

// File: rtl/playfair_digraph_cipher.sv
// Top level of the Playfair digraph cipher: APB configuration registers,
// controller and datapath. Depends on pfc_pkg, pfc_in_if, pfc_out_if,
// pfc_ctrl and pfc_datapath.
//
// Usage:
//   in_ch carries items (operation, letter_first, letter_second, unpaired);
//   every item yields exactly one result on out_ch (cipher_first,
//   cipher_second, status). A transfer happens when valid and ready are high.
//   Build a square with a start item, key letter items and a finish item,
//   then send encrypt items.
// Sequence:
//   Items are accepted, which reads the letter positions, then run their
//   action and load the result register; encrypt letters come from the
//   square memory. A finish item on an unfinished square first runs the
//   walk, which walks the letters one per cycle, and then loads the result.
// Reset (rst, synchronous): the square is empty and not finished, the result
//   register is empty, omitted_letter = Q (16), pad_letter = Z (25).
// Stall: a result waits in the result register until taken; the next item is
//   accepted meanwhile and holds in its execute step until the register frees.
// Configuration: omitted_letter at byte 0, pad_letter at byte 4; write only
//   while the block is idle.
module playfair_digraph_cipher import pfc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  pfc_in_if.sink      in_ch,
  pfc_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [LETTER_W-1:0] omitted_letter;
  logic [LETTER_W-1:0] pad_letter;
  reg_idx_t            reg_sel;
  logic                cfg_write;

  pfc_cmd_t            cmd;
  pfc_stat_t           stat;

  // Register index comes from the word address; byte lanes are ignored.
  assign reg_sel   = reg_idx_t'(paddr[2]);
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      omitted_letter <= OMIT_RESET;
      pad_letter     <= PAD_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_OMITTED: omitted_letter <= pwdata[LETTER_W-1:0];
        REG_PAD:     pad_letter     <= pwdata[LETTER_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_OMITTED: prdata = 32'(omitted_letter);
      REG_PAD:     prdata = 32'(pad_letter);
      default:     prdata = '0;
    endcase
  end

  // Sequencer: accept, execute, alphabet walk.
  pfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Square memories and result register.
  pfc_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .omitted_letter    (omitted_letter),
    .pad_letter        (pad_letter),
    .in_operation      (in_ch.operation),
    .in_letter_first   (in_ch.letter_first),
    .in_letter_second  (in_ch.letter_second),
    .in_unpaired       (in_ch.unpaired),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_cipher_first  (out_ch.cipher_first),
    .out_cipher_second (out_ch.cipher_second),
    .out_status        (out_ch.status)
  );

endmodule

// File: tb/tb_playfair_digraph_cipher.sv
// Self-checking testbench for playfair_digraph_cipher: a square tracker predicts each result.
// Depends on pfc_pkg, pfc_in_if, pfc_out_if and the playfair_digraph_cipher RTL.
`timescale 1ns / 1ps

module tb_playfair_digraph_cipher import pfc_pkg::*; ();

  // One plaintext item and one cipher result, at the block's field widths.
  typedef struct packed {
    op_t                 op;
    logic [LETTER_W-1:0] l1;
    logic [LETTER_W-1:0] l2;
    logic                unp;
  } plain_item_t;

  typedef struct packed {
    logic [LETTER_W-1:0] c1;
    logic [LETTER_W-1:0] c2;
    status_t             st;
  } cipher_res_t;

  // Tracks the key square as the block should build it and queues the
  // cipher result every accepted item must produce.
  class square_tracker;
    logic [LETTER_W-1:0] omit_ltr = OMIT_RESET;
    logic [LETTER_W-1:0] pad_ltr  = PAD_RESET;
    logic [LETTER_W-1:0] cell_ltr [CELLS];
    int                  ltr_pos  [LETTERS];
    bit                  ltr_used [LETTERS];
    int                  fill;
    bit                  sq_ready;
    cipher_res_t         pending_ciphers [$];
    int                  bad_results;

    function void set_register(reg_idx_t idx, logic [LETTER_W-1:0] v);
      if (idx == REG_OMITTED) omit_ltr = v;
      else pad_ltr = v;
    endfunction

    function void place(int ltr);
      if (ltr >= LETTERS || ltr_used[ltr] || fill >= CELLS) return;
      cell_ltr[fill] = LETTER_W'(ltr);
      ltr_pos[ltr]   = fill;
      ltr_used[ltr]  = 1'b1;
      fill++;
    endfunction

    function logic [LETTER_W-1:0] cell_at(int row, int col);
      return cell_ltr[(row % SIDE) * SIDE + (col % SIDE)];
    endfunction

    function void note_item(plain_item_t it);
      cipher_res_t         r;
      logic [LETTER_W-1:0] second;
      int                  r1, k1, r2, k2;
      r = '0;
      r.st = ST_OK;
      case (it.op)
        OP_START: begin
          foreach (ltr_used[i]) ltr_used[i] = 1'b0;
          fill = 0;
          sq_ready = 1'b0;
        end
        OP_KEY: begin
          if (it.l1 > LAST_LETTER) r.st = ST_NOT_IN_SQUARE;
          else if (!sq_ready && it.l1 != omit_ltr) place(it.l1);
        end
        OP_FINISH: begin
          if (!sq_ready) begin
            for (int k = 0; k < LETTERS; k++)
              if (k != omit_ltr) place(k);
            sq_ready = 1'b1;
          end
        end
        default: begin
          second = it.unp ? pad_ltr : it.l2;
          if (!sq_ready) begin
            r.st = ST_NOT_READY;
          end else if (it.l1 > LAST_LETTER || second > LAST_LETTER ||
                       !ltr_used[it.l1] || !ltr_used[second]) begin
            r.st = ST_NOT_IN_SQUARE;
          end else begin
            r1 = ltr_pos[it.l1] / SIDE;
            k1 = ltr_pos[it.l1] % SIDE;
            r2 = ltr_pos[second] / SIDE;
            k2 = ltr_pos[second] % SIDE;
            if (k1 == k2) begin
              r.c1 = cell_at(r1 + 1, k1);
              r.c2 = cell_at(r2 + 1, k2);
            end else if (r1 == r2) begin
              r.c1 = cell_at(r1, k1 + 1);
              r.c2 = cell_at(r2, k2 + 1);
            end else begin
              r.c1 = cell_at(r1, k2);
              r.c2 = cell_at(r2, k1);
            end
          end
        end
      endcase
      pending_ciphers.push_back(r);
    endfunction

    function void check_result(cipher_res_t got);
      cipher_res_t want;
      if (pending_ciphers.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("[%0t] unexpected result: c1=%0d c2=%0d status=%0d",
                   $realtime, got.c1, got.c2, got.st);
        return;
      end
      want = pending_ciphers.pop_front();
      if (got.c1 !== want.c1 || got.c2 !== want.c2 || got.st !== want.st) begin
        bad_results++;
        if (bad_results <= 10)
          $display("[%0t] MISMATCH expected c1=%0d c2=%0d status=%0d, got c1=%0d c2=%0d status=%0d",
                   $realtime, want.c1, want.c2, want.st, got.c1, got.c2, got.st);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pfc_in_if  in_ch ();
  pfc_out_if out_ch ();

  square_tracker board = new();
  int            items_sent;
  int            tx_burst;

  playfair_digraph_cipher dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // Idle gap drawn at random before the next transfer on one side, with
  // occasional stretches where that side never idles.
  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 11) == 0) begin
      burst = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  function automatic plain_item_t make_item(op_t op, int a, int b, int u);
    plain_item_t it;
    it.op  = op;
    it.l1  = LETTER_W'(a);
    it.l2  = LETTER_W'(b);
    it.unp = (u != 0);
    return it;
  endfunction

  // Mostly real letters, now and then a code above Z so the top bits toggle.
  function automatic int rand_letter();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(26, 31) : $urandom_range(0, 25);
  endfunction

  function automatic plain_item_t rand_pair();
    int a;
    a = rand_letter();
    return make_item(OP_ENCRYPT, a, ($urandom_range(0, 9) == 0) ? a : rand_letter(),
                     $urandom_range(0, 6) == 0);
  endfunction

  // Present one item, hold it until the transfer, then log the prediction.
  // Called on a rising edge; valid gets a single update per edge.
  task automatic send_item(plain_item_t it);
    int gap;
    gap = draw_wait(tx_burst);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= it.op;
    in_ch.letter_first  <= it.l1;
    in_ch.letter_second <= it.l2;
    in_ch.unpaired      <= it.unp;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    board.note_item(it);
    items_sent++;
  endtask

  // APB write: setup phase, then access until pready; update the tracker at
  // the edge where the register takes the value. Then return the bus to idle
  // so a following write starts on a fresh edge.
  task automatic write_register(reg_idx_t idx, logic [LETTER_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    board.set_register(idx, v);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Hold off until every predicted result has been taken, then let the
  // block settle before touching its registers.
  task automatic drain_results();
    while (board.pending_ciphers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result side: stall at random, take each result and check it.
  initial begin : result_sink
    int          stall;
    int          rx_burst;
    cipher_res_t got;
    rx_burst = 0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = draw_wait(rx_burst);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got.c1 = out_ch.cipher_first;
      got.c2 = out_ch.cipher_second;
      got.st = status_t'(out_ch.status);
      board.check_result(got);
    end
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin : watchdog
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int                  phase;
    int                  nkeys;
    int                  npairs;
    int                  next_key;
    int                  spin;
    int                  tmp;
    int                  j;
    int                  order [LETTERS];
    int                  keyword [9];
    bit                  mid_build;
    logic [LETTER_W-1:0] omit_v;
    logic [LETTER_W-1:0] pad_v;

    in_ch.valid         <= 1'b0;
    in_ch.operation     <= OP_START;
    in_ch.letter_first  <= '0;
    in_ch.letter_second <= '0;
    in_ch.unpaired      <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    items_sent = 0;
    tx_burst   = 0;
    keyword    = '{15, 11, 0, 24, 5, 8, 17, 4, 23};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: Q omitted, Z as pad, key letters P L A Y F I R E X.
    write_register(REG_OMITTED, 5'd16);
    write_register(REG_PAD, 5'd25);
    send_item(make_item(OP_ENCRYPT, 7, 4, 0));     // square not built yet
    send_item(make_item(OP_START, 0, 0, 0));
    send_item(make_item(OP_KEY, 31, 0, 0));        // code above Z
    send_item(make_item(OP_KEY, 16, 0, 0));        // omitted letter, skipped
    foreach (keyword[i])
      send_item(make_item(OP_KEY, keyword[i], 0, 0));
    send_item(make_item(OP_KEY, 15, 0, 0));        // repeated letter, skipped
    send_item(make_item(OP_FINISH, 0, 0, 0));
    send_item(make_item(OP_FINISH, 0, 0, 0));      // second finish changes nothing
    send_item(make_item(OP_KEY, 2, 0, 0));         // key after finish, ignored
    send_item(make_item(OP_ENCRYPT, 4, 4, 0));     // doubled letter: column rule
    send_item(make_item(OP_ENCRYPT, 15, 24, 0));   // same row
    send_item(make_item(OP_ENCRYPT, 15, 8, 0));    // same column
    send_item(make_item(OP_ENCRYPT, 0, 23, 0));    // rectangle
    send_item(make_item(OP_ENCRYPT, 16, 0, 0));    // omitted letter in pair
    send_item(make_item(OP_ENCRYPT, 31, 0, 0));    // code above Z in pair
    send_item(make_item(OP_ENCRYPT, 0, 30, 1));    // pad replaces second letter
    send_item(make_item(OP_ENCRYPT, 0, 30, 0));    // second letter above Z
    send_item(make_item(OP_ENCRYPT, 25, 0, 0));
    in_ch.valid <= 1'b0;

    // Random part: each phase drains, reprograms both registers, then either
    // keeps the current square, builds a fresh one, or resumes a build that
    // the previous phase left open so the omitted letter changes mid-build.
    phase     = 0;
    mid_build = 1'b0;
    while (items_sent < 1000) begin
      drain_results();
      if (phase == 0) begin
        omit_v = 5'd25;
        pad_v  = 5'd0;
      end else if (phase == 1) begin
        omit_v = 5'd0;
        pad_v  = 5'd25;
      end else begin
        omit_v = LETTER_W'($urandom_range(0, 25));
        pad_v  = ($urandom_range(0, 5) == 0) ? omit_v : LETTER_W'($urandom_range(0, 25));
      end
      write_register(REG_OMITTED, omit_v);
      write_register(REG_PAD, pad_v);

      if (mid_build || $urandom_range(0, 6) != 0) begin
        if (!mid_build) send_item(make_item(OP_START, rand_letter(), rand_letter(),
                                            $urandom_range(0, 1)));
        // Key letters walk a shuffled alphabet, so long keys can fill the square.
        foreach (order[i]) order[i] = i;
        for (int i = LETTERS - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        nkeys    = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 30) : $urandom_range(0, 12);
        next_key = 0;
        for (int i = 0; i < nkeys; i++) begin
          case ($urandom_range(0, 19))
            0:       send_item(make_item(OP_KEY, $urandom_range(26, 31), rand_letter(), 0));
            1, 2, 3: send_item(make_item(OP_KEY, $urandom_range(0, 25), rand_letter(), 1));
            default: begin
              send_item(make_item(OP_KEY, order[next_key % LETTERS], rand_letter(),
                                  $urandom_range(0, 1)));
              next_key++;
            end
          endcase
        end
        mid_build = ($urandom_range(0, 4) == 0);
        if (!mid_build) begin
          send_item(make_item(OP_FINISH, rand_letter(), rand_letter(), $urandom_range(0, 1)));
          if ($urandom_range(0, 9) == 0) send_item(make_item(OP_FINISH, 0, 0, 0));
        end
      end

      // Pairs; an open build makes these come back as not finished.
      npairs = mid_build ? $urandom_range(1, 4) : $urandom_range(15, 45);
      for (int i = 0; i < npairs; i++) begin
        if ($urandom_range(0, 32) == 0)
          send_item(make_item(op_t'($urandom_range(0, 3)), $urandom_range(0, 31),
                              $urandom_range(0, 31), $urandom_range(0, 1)));
        else
          send_item(rand_pair());
      end
      in_ch.valid <= 1'b0;
      phase++;
    end

    // Wait out the last results, then a tail to catch any stray extra one.
    for (spin = 0; spin < 20000 && board.pending_ciphers.size() != 0; spin++)
      @(posedge clk);
    repeat (60) @(posedge clk);
    board.bad_results += board.pending_ciphers.size();
    if (board.bad_results == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
